// ----- sv/ufpt_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ufpt_pkg
// Shared types, widths and datapath operation codes of the percolation tracker.
// ----------------------------------------------------------------------------
package ufpt_pkg;

    localparam int NODES  = 4096;
    localparam int AW     = 12;
    localparam int CW     = 13;
    localparam int EW     = 15;
    localparam int SQW    = 25;
    localparam int MW     = 21;
    localparam int DVW    = 33;
    localparam int RESW   = 85;
    localparam int OUTW   = 88;

    localparam logic [CW-1:0] NODES_C    = 13'd4096;
    localparam logic [MW-1:0] MEAN_ONE   = 21'd256;

    localparam logic [1:0] KIND_CLEAR  = 2'd0;
    localparam logic [1:0] KIND_OCCUPY = 2'd1;
    localparam logic [1:0] KIND_MERGE  = 2'd2;
    localparam logic [1:0] KIND_REPORT = 2'd3;

    typedef logic [4:0] op_t;

    localparam op_t OP_NONE          = 5'd0;
    localparam op_t OP_LOAD          = 5'd1;
    localparam op_t OP_CLR_WR        = 5'd2;
    localparam op_t OP_RD_IDX        = 5'd3;
    localparam op_t OP_RD_CUR        = 5'd4;
    localparam op_t OP_OCC_NEW       = 5'd5;
    localparam op_t OP_FIND_INIT_IDX = 5'd6;
    localparam op_t OP_FIND_INIT_CUR = 5'd7;
    localparam op_t OP_F_RD          = 5'd8;
    localparam op_t OP_F_STEP        = 5'd9;
    localparam op_t OP_C_RD          = 5'd10;
    localparam op_t OP_C_STEP        = 5'd11;
    localparam op_t OP_SAVE_CUR      = 5'd12;
    localparam op_t OP_SAVE_R1       = 5'd13;
    localparam op_t OP_M_EQ          = 5'd14;
    localparam op_t OP_M_W1          = 5'd15;
    localparam op_t OP_M_W2          = 5'd16;
    localparam op_t OP_S_RD          = 5'd17;
    localparam op_t OP_S_EV          = 5'd18;
    localparam op_t OP_S_ACC         = 5'd19;
    localparam op_t OP_DIV_START     = 5'd20;
    localparam op_t OP_OUT           = 5'd21;

    typedef struct packed {
        logic          occ;
        logic          root;
        logic [CW-1:0] val;
    } entry_t;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       in_range;
        logic       lim_zero;
        logic       e_occ;
        logic       e_root;
        logic       e_val_hi;
        logic       n_eq_r;
        logic       r_eq;
        logic       clr_last;
        logic       scan_last;
        logic       have_two;
        logic       div_busy;
        logic       out_free;
    } dp_stat_t;

endpackage
`default_nettype wire

// ----- sv/union_find_percolation_tracker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// union_find_percolation_tracker
// Site percolation cluster tracker built on a disjoint-set forest.
// ----------------------------------------------------------------------------
// Requests are taken one at a time, and each runs against a 4096-entry node
// table in a single-port-read RAM with registered read data. A clear request
// writes all 4096 entries; the table holds garbage until the first clear.
// Occupy and merge requests walk and compress each parent chain they touch.
// A report request scans node_count entries (capped at 4096), then, when it
// has found at least two clusters, runs a bit-serial divide for the mean. A
// finished report waits in an output register and does not block new requests;
// a later report is held back until the earlier one has been taken.
module union_find_percolation_tracker
    import ufpt_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    input  wire logic [15:0]     s_tdata,   // [11:0] node_index
    input  wire logic [1:0]      s_tuser,   // [1:0] kind
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    output logic      [OUTW-1:0] m_tdata,   // largest_size, second_size,
                                            // rest_square_sum, rest_size_sum,
                                            // mean_size_fixed
    input  wire logic            cfg_we,
    input  wire logic [CW-1:0]   cfg_wdata
);

    dp_cmd_t  cmd;
    dp_stat_t stat;
    logic     ram_we;

    ufpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ufpt_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_kind   (s_tuser),
        .in_index  (s_tdata[AW-1:0]),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .ram_we    (ram_we)
    );

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another is in progress");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> !s_tready)
        else $error("table written while idle");

    a_div_busy: assert property (@(posedge clk) disable iff (!rst_n)
        stat.div_busy |-> (!s_tready && (cmd.op != OP_OUT)))
        else $error("result or request handled during divide");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_OUT) |-> (!m_tvalid || m_tready))
        else $error("pending result overwritten");

endmodule
`default_nettype wire

// ----- sv/ufpt_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ufpt_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ufpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ----- sv/ufpt_div.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ufpt_div
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ufpt_div
    import ufpt_pkg::*;
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           start,
    input  wire logic [DVW-1:0] dividend,
    input  wire logic [CW-1:0]  divisor,
    output logic                busy,
    output logic      [DVW-1:0] quotient
);

    logic [DVW-1:0] q_reg, q_next;
    logic [CW-1:0]  rem_reg, rem_next;
    logic [5:0]     cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic [CW:0]    rem_sh;
    logic [CW:0]    rem_sub;
    logic           ge;

    assign rem_sh  = {rem_reg, q_reg[DVW-1]};
    assign ge      = rem_sh >= {1'b0, divisor};
    assign rem_sub = rem_sh - {1'b0, divisor};

    always_comb
    begin
        q_next    = q_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            q_next    = dividend;
            rem_next  = '0;
            cnt_next  = 6'(DVW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[DVW-2:0], ge};
            rem_next = ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
    end

    assign busy     = busy_reg;
    assign quotient = q_reg;

endmodule
`default_nettype wire

// ----- sv/ufpt_dp.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ufpt_dp
// Datapath: node table, walk pointers, scan statistics, divider and result.
// ----------------------------------------------------------------------------
module ufpt_dp
    import ufpt_pkg::*;
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire dp_cmd_t         cmd,
    output dp_stat_t             stat,
    input  wire logic [1:0]      in_kind,
    input  wire logic [AW-1:0]   in_index,
    input  wire logic            cfg_we,
    input  wire logic [CW-1:0]   cfg_wdata,
    input  wire logic            m_tready,
    output logic                 m_tvalid,
    output logic      [OUTW-1:0] m_tdata,
    output logic                 ram_we
);

    logic [1:0]    kind_reg;
    logic [AW-1:0] idx_reg, cur_reg, cand_reg, start_reg, ptr_reg, r1_reg;
    logic [CW-1:0] psize_reg, s1_reg, scan_reg, count_reg;
    logic [CW-1:0] largest_reg, second_reg, sum_reg, sv_reg;
    logic [SQW-1:0] sq_reg;
    logic          have_one_reg, have_two_reg;
    logic [RESW-1:0] out_reg;
    logic          out_valid_reg;

    logic [AW-1:0] raddr, waddr;
    logic [EW-1:0] rdata_raw, wdata_raw;
    entry_t        e, wentry;
    logic [CW-1:0] lim;
    logic [CW-1:0] msum;
    logic [CW:0]   msum_w;
    logic [2*CW-1:0] sq_prod;
    logic          f_done;
    logic          s1_lt;
    logic          div_busy;
    logic [DVW-1:0] quot;
    logic [MW-1:0] mean;

    assign e       = entry_t'(rdata_raw);
    assign lim     = (count_reg > NODES_C) ? NODES_C : count_reg;
    assign msum_w  = {1'b0, s1_reg} + {1'b0, psize_reg};
    assign msum    = msum_w[CW-1:0];
    assign sq_prod = sv_reg * sv_reg;
    assign f_done  = !e.occ || e.root || e.val[CW-1];
    assign s1_lt   = s1_reg < psize_reg;
    assign mean    = have_two_reg ? quot[MW-1:0] : MEAN_ONE;

    always_comb
    begin
        raddr  = cand_reg;
        waddr  = cand_reg;
        wentry = '0;
        ram_we = 1'b0;
        case (cmd.op)
            OP_RD_IDX: raddr = idx_reg;
            OP_RD_CUR: raddr = cur_reg;
            OP_S_RD:   raddr = scan_reg[AW-1:0];
            OP_CLR_WR:
            begin
                ram_we = 1'b1;
                waddr  = scan_reg[AW-1:0];
            end
            OP_OCC_NEW:
            begin
                ram_we = 1'b1;
                waddr  = idx_reg;
                wentry = '{occ: 1'b1, root: 1'b1, val: 13'd1};
            end
            OP_C_STEP:
            begin
                ram_we = 1'b1;
                wentry = '{occ: e.occ, root: e.root, val: {1'b0, ptr_reg}};
            end
            OP_M_W1:
            begin
                ram_we = 1'b1;
                waddr  = s1_lt ? ptr_reg : r1_reg;
                wentry = '{occ: 1'b1, root: 1'b1, val: msum};
            end
            OP_M_W2:
            begin
                ram_we = 1'b1;
                waddr  = s1_lt ? r1_reg : ptr_reg;
                wentry = '{occ: 1'b1, root: 1'b0,
                           val: {1'b0, (s1_lt ? ptr_reg : r1_reg)}};
            end
            default: ;
        endcase
    end

    assign wdata_raw = EW'(wentry);

    ufpt_ram #(
        .WIDTH (EW),
        .DEPTH (NODES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (waddr),
        .wdata (wdata_raw),
        .raddr (raddr),
        .rdata (rdata_raw)
    );

    ufpt_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.op == OP_DIV_START),
        .dividend ({sq_reg, 8'b0}),
        .divisor  (sum_reg),
        .busy     (div_busy),
        .quotient (quot)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_reg       <= '0;
            count_reg     <= NODES_C;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
            case (cmd.op)
                OP_CLR_WR:
                begin
                    if (scan_reg[AW-1:0] == {AW{1'b1}})
                    begin
                        cur_reg <= '0;
                    end
                end
                OP_OCC_NEW:  cur_reg <= idx_reg;
                OP_SAVE_CUR: cur_reg <= ptr_reg;
                OP_M_EQ:     cur_reg <= r1_reg;
                OP_M_W2:     cur_reg <= s1_lt ? ptr_reg : r1_reg;
                default: ;
            endcase
            if (cmd.op == OP_OUT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                kind_reg     <= in_kind;
                idx_reg      <= in_index;
                scan_reg     <= '0;
                largest_reg  <= '0;
                second_reg   <= '0;
                sum_reg      <= '0;
                sq_reg       <= '0;
                sv_reg       <= '0;
                have_one_reg <= 1'b0;
                have_two_reg <= 1'b0;
            end
            OP_CLR_WR: scan_reg <= scan_reg + 13'd1;
            OP_FIND_INIT_IDX:
            begin
                cand_reg  <= idx_reg;
                start_reg <= idx_reg;
                ptr_reg   <= idx_reg;
            end
            OP_FIND_INIT_CUR:
            begin
                cand_reg  <= cur_reg;
                start_reg <= cur_reg;
                ptr_reg   <= cur_reg;
            end
            OP_F_STEP:
            begin
                if (e.occ)
                begin
                    ptr_reg   <= cand_reg;
                    psize_reg <= e.val;
                end
                cand_reg <= f_done ? start_reg : e.val[AW-1:0];
            end
            OP_C_STEP: cand_reg <= e.val[AW-1:0];
            OP_SAVE_R1:
            begin
                r1_reg <= ptr_reg;
                s1_reg <= psize_reg;
            end
            OP_S_EV:
            begin
                sv_reg <= '0;
                if (e.occ && e.root)
                begin
                    if (!have_one_reg)
                    begin
                        have_one_reg <= 1'b1;
                        largest_reg  <= e.val;
                    end
                    else
                    begin
                        have_two_reg <= 1'b1;
                        if (e.val > largest_reg)
                        begin
                            largest_reg <= e.val;
                            sv_reg      <= largest_reg;
                            sum_reg     <= sum_reg + largest_reg;
                            if (largest_reg > second_reg)
                            begin
                                second_reg <= largest_reg;
                            end
                        end
                        else
                        begin
                            sv_reg  <= e.val;
                            sum_reg <= sum_reg + e.val;
                            if (e.val > second_reg)
                            begin
                                second_reg <= e.val;
                            end
                        end
                    end
                end
            end
            OP_S_ACC:
            begin
                sq_reg   <= sq_reg + sq_prod[SQW-1:0];
                scan_reg <= scan_reg + 13'd1;
            end
            OP_OUT: out_reg <= {mean, sum_reg, sq_reg, second_reg, largest_reg};
            default: ;
        endcase
    end

    always_comb
    begin
        stat.kind      = kind_reg;
        stat.in_range  = {1'b0, idx_reg} < lim;
        stat.lim_zero  = lim == '0;
        stat.e_occ     = e.occ;
        stat.e_root    = e.root;
        stat.e_val_hi  = e.val[CW-1];
        stat.n_eq_r    = cand_reg == ptr_reg;
        stat.r_eq      = r1_reg == ptr_reg;
        stat.clr_last  = scan_reg[AW-1:0] == {AW{1'b1}};
        stat.scan_last = (scan_reg + 13'd1) >= lim;
        stat.have_two  = have_two_reg;
        stat.div_busy  = div_busy;
        stat.out_free  = !out_valid_reg || m_tready;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(OUTW-RESW){1'b0}}, out_reg};

endmodule
`default_nettype wire

// ----- sv/ufpt_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ufpt_ctrl
// Controller that sequences requests into datapath operations.
// ----------------------------------------------------------------------------
module ufpt_ctrl
    import ufpt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     s_tvalid,
    output logic          s_tready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    localparam logic [4:0] ST_IDLE     = 5'd0;
    localparam logic [4:0] ST_DISP     = 5'd1;
    localparam logic [4:0] ST_CLR      = 5'd2;
    localparam logic [4:0] ST_OCC_RD   = 5'd3;
    localparam logic [4:0] ST_OCC_CHK  = 5'd4;
    localparam logic [4:0] ST_MRG_RD   = 5'd5;
    localparam logic [4:0] ST_MRG_CHK  = 5'd6;
    localparam logic [4:0] ST_MRG_CHK2 = 5'd7;
    localparam logic [4:0] ST_F_RD     = 5'd8;
    localparam logic [4:0] ST_F_CHK    = 5'd9;
    localparam logic [4:0] ST_C_RD     = 5'd10;
    localparam logic [4:0] ST_C_CHK    = 5'd11;
    localparam logic [4:0] ST_RET      = 5'd12;
    localparam logic [4:0] ST_F2_INIT  = 5'd13;
    localparam logic [4:0] ST_M_W1     = 5'd14;
    localparam logic [4:0] ST_M_W2     = 5'd15;
    localparam logic [4:0] ST_S_RD     = 5'd16;
    localparam logic [4:0] ST_S_EV     = 5'd17;
    localparam logic [4:0] ST_S_ACC    = 5'd18;
    localparam logic [4:0] ST_DIV      = 5'd19;
    localparam logic [4:0] ST_DIV_WAIT = 5'd20;
    localparam logic [4:0] ST_OUT      = 5'd21;

    localparam logic [1:0] RET_OCC = 2'd0;
    localparam logic [1:0] RET_M1  = 2'd1;
    localparam logic [1:0] RET_M2  = 2'd2;

    logic [4:0] state_reg, state_next;
    logic [1:0] ret_reg, ret_next;

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd.op     = OP_NONE;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_DISP;
                end
            end
            ST_DISP:
            begin
                case (stat.kind)
                    KIND_CLEAR:  state_next = ST_CLR;
                    KIND_OCCUPY: state_next = stat.in_range ? ST_OCC_RD : ST_IDLE;
                    KIND_MERGE:  state_next = stat.in_range ? ST_MRG_RD : ST_IDLE;
                    default:     state_next = stat.lim_zero ? ST_DIV : ST_S_RD;
                endcase
            end
            ST_CLR:
            begin
                cmd.op = OP_CLR_WR;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_OCC_RD:
            begin
                cmd.op     = OP_RD_IDX;
                state_next = ST_OCC_CHK;
            end
            ST_OCC_CHK:
            begin
                if (stat.e_occ)
                begin
                    cmd.op     = OP_FIND_INIT_IDX;
                    ret_next   = RET_OCC;
                    state_next = ST_F_RD;
                end
                else
                begin
                    cmd.op     = OP_OCC_NEW;
                    state_next = ST_IDLE;
                end
            end
            ST_MRG_RD:
            begin
                cmd.op     = OP_RD_IDX;
                state_next = ST_MRG_CHK;
            end
            ST_MRG_CHK:
            begin
                if (stat.e_occ)
                begin
                    cmd.op     = OP_RD_CUR;
                    state_next = ST_MRG_CHK2;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MRG_CHK2:
            begin
                if (stat.e_occ)
                begin
                    cmd.op     = OP_FIND_INIT_CUR;
                    ret_next   = RET_M1;
                    state_next = ST_F_RD;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_F_RD:
            begin
                cmd.op     = OP_F_RD;
                state_next = ST_F_CHK;
            end
            ST_F_CHK:
            begin
                cmd.op = OP_F_STEP;
                if (!stat.e_occ || stat.e_root || stat.e_val_hi)
                begin
                    state_next = ST_C_RD;
                end
                else
                begin
                    state_next = ST_F_RD;
                end
            end
            ST_C_RD:
            begin
                if (stat.n_eq_r)
                begin
                    state_next = ST_RET;
                end
                else
                begin
                    cmd.op     = OP_C_RD;
                    state_next = ST_C_CHK;
                end
            end
            ST_C_CHK:
            begin
                if (stat.e_root)
                begin
                    state_next = ST_RET;
                end
                else
                begin
                    cmd.op     = OP_C_STEP;
                    state_next = stat.e_val_hi ? ST_RET : ST_C_RD;
                end
            end
            ST_RET:
            begin
                case (ret_reg)
                    RET_OCC:
                    begin
                        cmd.op     = OP_SAVE_CUR;
                        state_next = ST_IDLE;
                    end
                    RET_M1:
                    begin
                        cmd.op     = OP_SAVE_R1;
                        state_next = ST_F2_INIT;
                    end
                    default:
                    begin
                        if (stat.r_eq)
                        begin
                            cmd.op     = OP_M_EQ;
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            state_next = ST_M_W1;
                        end
                    end
                endcase
            end
            ST_F2_INIT:
            begin
                cmd.op     = OP_FIND_INIT_IDX;
                ret_next   = RET_M2;
                state_next = ST_F_RD;
            end
            ST_M_W1:
            begin
                cmd.op     = OP_M_W1;
                state_next = ST_M_W2;
            end
            ST_M_W2:
            begin
                cmd.op     = OP_M_W2;
                state_next = ST_IDLE;
            end
            ST_S_RD:
            begin
                cmd.op     = OP_S_RD;
                state_next = ST_S_EV;
            end
            ST_S_EV:
            begin
                cmd.op     = OP_S_EV;
                state_next = ST_S_ACC;
            end
            ST_S_ACC:
            begin
                cmd.op     = OP_S_ACC;
                state_next = stat.scan_last ? ST_DIV : ST_S_RD;
            end
            ST_DIV:
            begin
                if (stat.have_two)
                begin
                    cmd.op     = OP_DIV_START;
                    state_next = ST_DIV_WAIT;
                end
                else
                begin
                    state_next = ST_OUT;
                end
            end
            ST_DIV_WAIT:
            begin
                if (!stat.div_busy)
                begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.op     = OP_OUT;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= RET_OCC;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

endmodule
`default_nettype wire

// ----- dv/union_find_percolation_tracker_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// union_find_percolation_tracker_tb
// Self-checking bench for the percolation cluster tracker. Clear, occupy,
// merge and report requests stream into the block under several node counts
// and backpressure profiles. A cluster forest kept beside the block predicts
// every report, which is compared field by field.
// ----------------------------------------------------------------------------
module union_find_percolation_tracker_tb;
    import ufpt_pkg::*;

    localparam int WATCHDOG_LIMIT = 100000;
    localparam int HOLD_CYCLES    = 3000;

    typedef struct packed {
        logic [MW-1:0]  mean;
        logic [CW-1:0]  rest_sum;
        logic [SQW-1:0] rest_sq;
        logic [CW-1:0]  second;
        logic [CW-1:0]  largest;
    } cluster_report_t;

    class cluster_scoreboard;
        bit          occ [NODES];
        bit          is_root [NODES];
        int unsigned val [NODES];
        int unsigned cur_root;
        int unsigned node_limit;
        cluster_report_t report_q[$];
        int          mismatches;

        function new();
            cur_root   = 0;
            node_limit = NODES;
            mismatches = 0;
        endfunction

        function void set_count(logic [CW-1:0] v);
            node_limit = (v > NODES) ? NODES : v;
        endfunction

        function int unsigned find_root(int unsigned start);
            int unsigned r;
            int unsigned n;
            int unsigned p;
            int unsigned steps;
            r = start;
            steps = 0;
            while (!is_root[r] && steps < NODES) begin
                p = val[r];
                if (p >= NODES || !occ[p])
                    break;
                r = p;
                steps++;
            end
            n = start;
            steps = 0;
            while (n != r && !is_root[n] && steps < NODES) begin
                p = val[n];
                val[n] = r;
                if (p >= NODES)
                    break;
                n = p;
                steps++;
            end
            return r;
        endfunction

        function void note_request(logic [1:0] kind, logic [AW-1:0] idx);
            int unsigned r1;
            int unsigned r2;
            longint unsigned big;
            longint unsigned sec;
            longint unsigned sq;
            longint unsigned sum;
            longint unsigned s;
            longint unsigned t;
            longint unsigned mean;
            int unsigned clusters;
            cluster_report_t rep;
            case (kind)
                KIND_CLEAR:
                begin
                    for (int i = 0; i < NODES; i++)
                    begin
                        occ[i] = 0;
                        is_root[i] = 0;
                        val[i] = 0;
                    end
                    cur_root = 0;
                end
                KIND_OCCUPY:
                begin
                    if (idx < node_limit)
                    begin
                        if (occ[idx])
                            cur_root = find_root(idx) & 12'hFFF;
                        else
                        begin
                            occ[idx] = 1;
                            is_root[idx] = 1;
                            val[idx] = 1;
                            cur_root = idx;
                        end
                    end
                end
                KIND_MERGE:
                begin
                    if (idx < node_limit && occ[idx] && cur_root < NODES && occ[cur_root])
                    begin
                        r1 = find_root(cur_root);
                        r2 = find_root(idx);
                        if (r1 != r2)
                        begin
                            if (val[r1] < val[r2])
                            begin
                                val[r2] += val[r1];
                                is_root[r1] = 0;
                                val[r1] = r2;
                                r1 = r2;
                            end
                            else
                            begin
                                val[r1] += val[r2];
                                is_root[r2] = 0;
                                val[r2] = r1;
                            end
                        end
                        cur_root = r1 & 12'hFFF;
                    end
                end
                default:
                begin
                    big = 0;
                    sec = 0;
                    sq = 0;
                    sum = 0;
                    clusters = 0;
                    for (int i = 0; i < node_limit; i++)
                    begin
                        if (occ[i] && is_root[i])
                        begin
                            s = val[i];
                            clusters++;
                            if (clusters == 1)
                                big = s;
                            else
                            begin
                                if (s > big)
                                begin
                                    t = big;
                                    big = s;
                                    s = t;
                                end
                                if (s > sec)
                                    sec = s;
                                sq += s * s;
                                sum += s;
                            end
                        end
                    end
                    mean = (clusters < 2 || sum == 0) ? 256 : (sq << 8) / sum;
                    rep.largest  = big[CW-1:0];
                    rep.second   = sec[CW-1:0];
                    rep.rest_sq  = sq[SQW-1:0];
                    rep.rest_sum = sum[CW-1:0];
                    rep.mean     = mean[MW-1:0];
                    report_q = {report_q, rep};
                end
            endcase
        endfunction

        task flag(string what, longint unsigned got, longint unsigned want);
            $display("mismatch: %s got %0d expected %0d", what, got, want);
            mismatches++;
        endtask

        task check_report(logic [OUTW-1:0] data);
            cluster_report_t got;
            cluster_report_t want;
            got = data[RESW-1:0];
            if (report_q.size() == 0)
                flag("unexpected report, largest", got.largest, 0);
            else
            begin
                want = report_q.pop_front();
                if (got.largest !== want.largest)
                    flag("largest_size", got.largest, want.largest);
                if (got.second !== want.second)
                    flag("second_size", got.second, want.second);
                if (got.rest_sq !== want.rest_sq)
                    flag("rest_square_sum", got.rest_sq, want.rest_sq);
                if (got.rest_sum !== want.rest_sum)
                    flag("rest_size_sum", got.rest_sum, want.rest_sum);
                if (got.mean !== want.mean)
                    flag("mean_size_fixed", got.mean, want.mean);
                if (data[OUTW-1:RESW] !== '0)
                    flag("padding", data[OUTW-1:RESW], 0);
            end
        endtask
    endclass

    logic            clk;
    logic            rst_n;
    logic            s_tvalid;
    logic            s_tready;
    logic [15:0]     s_tdata;
    logic [1:0]      s_tuser;
    logic            m_tvalid;
    logic            m_tready;
    logic [OUTW-1:0] m_tdata;
    logic            cfg_we;
    logic [CW-1:0]   cfg_wdata;

    cluster_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int hold_left;
    bit hold_start;
    int quiet_cycles;
    int unsigned cur_count;

    union_find_percolation_tracker uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    initial
    begin
        clk = 0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (hold_start)
        begin
            hold_left = HOLD_CYCLES;
            hold_start = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_report(m_tdata);
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task send_request(logic [1:0] kind, logic [AW-1:0] idx);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {4'b0, idx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        sb.note_request(kind, idx);
    endtask

    task drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.report_q.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task set_node_count(logic [CW-1:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.set_count(v);
        cur_count = (v > NODES) ? NODES : v;
    endtask

    task random_requests(int n, int report_pct);
        int unsigned pick;
        int unsigned top;
        logic [1:0] kind;
        logic [AW-1:0] idx;
        top = (cur_count + 1 > NODES - 1) ? NODES - 1 : cur_count + 1;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 2)
                kind = KIND_CLEAR;
            else if (pick < 47 - report_pct / 2)
                kind = KIND_OCCUPY;
            else if (pick < 100 - report_pct)
                kind = KIND_MERGE;
            else
                kind = KIND_REPORT;
            if ($urandom_range(9) < 8)
                idx = AW'($urandom_range(top));
            else
                idx = AW'($urandom);
            send_request(kind, idx);
        end
    endtask

    task run_phase(logic [CW-1:0] count, int n, int idle, int stall);
        set_node_count(count);
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        send_request(KIND_CLEAR, 0);
        random_requests(n, 12);
        send_request(KIND_REPORT, 0);
        drain();
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = KIND_CLEAR;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_left = 0;
        hold_start = 0;
        quiet_cycles = 0;
        cur_count = NODES;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_node_count(16);
        send_request(KIND_CLEAR, 0);
        send_request(KIND_REPORT, 0);
        send_request(KIND_MERGE, 0);
        send_request(KIND_OCCUPY, 3);
        send_request(KIND_OCCUPY, 3);
        send_request(KIND_OCCUPY, 20);
        send_request(KIND_MERGE, 5);
        send_request(KIND_OCCUPY, 5);
        send_request(KIND_MERGE, 3);
        send_request(KIND_OCCUPY, 7);
        send_request(KIND_MERGE, 5);
        send_request(KIND_OCCUPY, 9);
        send_request(KIND_OCCUPY, 10);
        send_request(KIND_MERGE, 9);
        send_request(KIND_REPORT, 0);
        send_request(KIND_OCCUPY, 15);
        send_request(KIND_OCCUPY, 16);
        send_request(KIND_MERGE, 12'hFFF);
        send_request(KIND_REPORT, 0);
        drain();

        set_node_count(NODES_C);
        send_request(KIND_CLEAR, 0);
        send_request(KIND_OCCUPY, 0);
        send_request(KIND_OCCUPY, 12'hFFF);
        send_request(KIND_MERGE, 0);
        send_request(KIND_REPORT, 0);
        drain();
        set_node_count(8);
        send_request(KIND_REPORT, 0);
        drain();

        run_phase(1, 150, 0, 0);
        run_phase(13, 300, 47, 0);
        run_phase(64, 400, 0, 47);
        run_phase(200, 300, 16, 16);
        run_phase(NODES_C, 15, 0, 0);
        run_phase(0, 30, 47, 47);
        run_phase(13'h1FFF, 15, 16, 16);

        set_node_count(13);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_request(KIND_CLEAR, 0);
        hold_start = 1;
        random_requests(60, 40);
        send_request(KIND_REPORT, 0);
        drain();

        repeat (50) @(posedge clk);
        if (sb.mismatches == 0 && sb.report_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/ufpt_pkg.sv
sv/ufpt_ram.sv
sv/ufpt_div.sv
sv/ufpt_dp.sv
sv/ufpt_ctrl.sv
sv/union_find_percolation_tracker.sv
dv/union_find_percolation_tracker_tb.sv
